// ===== rtl/eqi_pkg.sv =====
// eqi_pkg: shared types and constants for the empirical quantile interpolator
// used by eqi_cell, eqi_interp and empirical_quantile_interpolator_top
package eqi_pkg;

  localparam int DEPTH_DEFAULT = 64;   // sample store depth
  localparam int SAMPLE_W      = 32;   // sample and result width
  localparam int PROB_W        = 16;   // 0.16 probability
  localparam int FRAC_W        = 16;   // fraction bits of t and pos
  localparam int POS_W         = 19;   // pos lies in -2^15 .. 2^17
  localparam int COUNT_OUT_W   = 7;    // reported sample count width

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_LOAD  = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_FEW  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_IDX,
    ST_SEL,
    ST_MUL,
    ST_FIN
  } state_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic                        load;
    logic signed [SAMPLE_W-1:0]  value;
  } cell_ctl_t;

endpackage

// ===== rtl/eqi_cell.sv =====
// eqi_cell: one cell of the sorted sample chain, holds one sample
// depends on eqi_pkg
module eqi_cell #(
  parameter int INDEX   = 0,
  parameter int COUNT_W = 7,
  parameter int IDX_W   = 6
) (
  input  logic                                 clk,
  input  eqi_pkg::cell_ctl_t                   ctl,
  input  logic [COUNT_W-1:0]                   count,
  input  logic signed [eqi_pkg::SAMPLE_W-1:0]  left_sample,
  input  logic                                 left_gt,
  input  logic [IDX_W-1:0]                     rd_idx0,
  input  logic [IDX_W-1:0]                     rd_idx1,
  output logic signed [eqi_pkg::SAMPLE_W-1:0]  sample,
  output logic                                 gt,
  output logic [eqi_pkg::SAMPLE_W-1:0]         rd_data0,
  output logic [eqi_pkg::SAMPLE_W-1:0]         rd_data1
);
  import eqi_pkg::*;

  localparam logic [COUNT_W-1:0] MY_POS = COUNT_W'(INDEX);
  localparam logic [IDX_W-1:0]   MY_IDX = IDX_W'(INDEX);

  logic occupied;
  logic at_end;

  assign occupied = MY_POS < count;
  assign at_end   = MY_POS == count;
  // new sample goes after equal ones, so only strictly greater entries move
  assign gt       = occupied && (sample > ctl.value);

  always_ff @(posedge clk) begin
    if (ctl.load && (occupied || at_end)) begin
      if (left_gt) begin
        sample <= left_sample;
      end else if (gt || at_end) begin
        sample <= ctl.value;
      end
    end
  end

  assign rd_data0 = (rd_idx0 == MY_IDX) ? sample : '0;
  assign rd_data1 = (rd_idx1 == MY_IDX) ? sample : '0;

endmodule

// ===== rtl/eqi_interp.sv =====
// eqi_interp: interpolation arithmetic, product stage then round and saturate
// depends on eqi_pkg
module eqi_interp (
  input  logic                                 clk,
  input  logic                                 mul_en,
  input  logic signed [eqi_pkg::SAMPLE_W-1:0]  s0,
  input  logic signed [eqi_pkg::SAMPLE_W-1:0]  s1,
  input  logic signed [eqi_pkg::POS_W-1:0]     pos,
  output logic signed [eqi_pkg::SAMPLE_W-1:0]  result
);
  import eqi_pkg::*;

  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + POS_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int RND_W  = ACC_W - FRAC_W;

  localparam logic signed [RND_W-1:0] MAX_R = RND_W'(64'sd2147483647);
  localparam logic signed [RND_W-1:0] MIN_R = -RND_W'(64'sd2147483648);

  logic signed [DIFF_W-1:0]   diff;
  logic signed [PROD_W-1:0]   prod;
  logic signed [SAMPLE_W-1:0] base;
  logic signed [ACC_W-1:0]    acc;
  logic signed [RND_W-1:0]    rnd;

  assign diff = DIFF_W'(s1) - DIFF_W'(s0);

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= PROD_W'(pos) * PROD_W'(diff);
      base <= s0;
    end
  end

  // round to nearest, ties up
  assign acc = (ACC_W'(base) <<< FRAC_W) + ACC_W'(prod)
             + ACC_W'(1 << (FRAC_W - 1));
  assign rnd = RND_W'(acc >>> FRAC_W);

  always_comb begin
    if (rnd > MAX_R) begin
      result = SAMPLE_W'(MAX_R);
    end else if (rnd < MIN_R) begin
      result = SAMPLE_W'(MIN_R);
    end else begin
      result = SAMPLE_W'(rnd);
    end
  end

endmodule

// ===== rtl/empirical_quantile_interpolator_top.sv =====
// empirical_quantile_interpolator_top: sorted sample chain with quantile query
// clear, load and no-op go through the result buffer to the output register; query steps are
// product, index, select, multiply, round, output; one item in flight, next accepted after finish
// a short-store query (fewer than two samples) is answered like a clear, load or no-op
// reset: rst synchronous active high empties the store and drops buffered results
// depends on eqi_pkg, eqi_cell, eqi_interp
module empirical_quantile_interpolator_top #(
  parameter int DEPTH = eqi_pkg::DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // sample_value[31:0], prob[47:32]
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // quantile_value[31:0], sample_count[38:32], zero[39]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);
  import eqi_pkg::*;

  localparam int COUNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W   = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int T_W     = PROB_W + COUNT_W + 1;
  localparam int I_W     = COUNT_W + 1;

  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

  // input transfer fields
  func_t                      in_func;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic [PROB_W-1:0]          in_prob;
  logic                       in_xfer;

  assign in_func   = func_t'(s_axis_tuser);
  assign in_sample = s_axis_tdata[SAMPLE_W-1:0];
  assign in_prob   = s_axis_tdata[SAMPLE_W +: PROB_W];

  // control state
  state_t             state, state_next;
  logic [COUNT_W-1:0] count, count_next;

  // query registers
  logic signed [T_W-1:0]      t_val;
  logic [IDX_W-1:0]           idx0;
  logic [IDX_W-1:0]           idx1;
  logic signed [POS_W-1:0]    pos;
  logic signed [SAMPLE_W-1:0] s0_q;
  logic signed [SAMPLE_W-1:0] s1_q;

  // result buffer between the core and the output register
  logic                       done_valid;
  logic signed [SAMPLE_W-1:0] done_value;
  status_t                    done_status;
  logic [COUNT_OUT_W-1:0]     done_count;

  // output register
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_value;
  status_t                    out_status;
  logic [COUNT_OUT_W-1:0]     out_count;

  // cell chain wires
  cell_ctl_t                  ctl;
  logic signed [SAMPLE_W-1:0] cell_sample [DEPTH];
  logic                       cell_gt     [DEPTH];
  logic [SAMPLE_W-1:0]        cell_rd0    [DEPTH];
  logic [SAMPLE_W-1:0]        cell_rd1    [DEPTH];
  logic [SAMPLE_W-1:0]        sel0;
  logic [SAMPLE_W-1:0]        sel1;

  // index and position arithmetic
  logic signed [I_W-1:0]      i_raw;
  logic signed [I_W-1:0]      i_max;
  logic [IDX_W-1:0]           i_clamp;
  logic signed [T_W-1:0]      pos_full;

  logic                       mul_en;
  logic signed [SAMPLE_W-1:0] interp_result;
  logic                       fin;

  assign s_axis_tready = (state == ST_IDLE) && !done_valid;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // a load walks into the chain in the transfer cycle; fields are {load, value}
  assign ctl = {in_xfer && (in_func == FUNC_LOAD) && (count < FULL_COUNT), in_sample};

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic signed [SAMPLE_W-1:0] left_sample;
    logic                       left_gt;
    if (k == 0) begin : g_first
      assign left_sample = '0;
      assign left_gt     = 1'b0;
    end else begin : g_rest
      assign left_sample = cell_sample[k-1];
      assign left_gt     = cell_gt[k-1];
    end
    eqi_cell #(
      .INDEX   (k),
      .COUNT_W (COUNT_W),
      .IDX_W   (IDX_W)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .count       (count),
      .left_sample (left_sample),
      .left_gt     (left_gt),
      .rd_idx0     (idx0),
      .rd_idx1     (idx1),
      .sample      (cell_sample[k]),
      .gt          (cell_gt[k]),
      .rd_data0    (cell_rd0[k]),
      .rd_data1    (cell_rd1[k])
    );
  end

  // each cell drives its sample only when addressed, so an or picks it out
  always_comb begin
    sel0 = '0;
    sel1 = '0;
    for (int k = 0; k < DEPTH; k++) begin
      sel0 = sel0 | cell_rd0[k];
      sel1 = sel1 | cell_rd1[k];
    end
  end

  // i0 = floor(t), clamped to 0 .. n-2
  assign i_raw = I_W'(t_val >>> FRAC_W);
  assign i_max = $signed({1'b0, count}) - I_W'(2);

  always_comb begin
    if (i_raw < 0) begin
      i_clamp = '0;
    end else if (i_raw > i_max) begin
      i_clamp = IDX_W'(i_max);
    end else begin
      i_clamp = IDX_W'(i_raw);
    end
  end

  assign pos_full = t_val - (T_W'({1'b0, i_clamp}) <<< FRAC_W);

  eqi_interp u_interp (
    .clk    (clk),
    .mul_en (mul_en),
    .s0     (s0_q),
    .s1     (s1_q),
    .pos    (pos),
    .result (interp_result)
  );

  // next state and control strobes
  always_comb begin
    state_next = state;
    count_next = count;
    mul_en     = 1'b0;
    fin        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_func)
            FUNC_CLEAR: count_next = '0;
            FUNC_LOAD: begin
              if (count < FULL_COUNT) begin
                count_next = count + COUNT_W'(1);
              end
            end
            FUNC_QUERY: begin
              if (count >= COUNT_W'(2)) begin
                state_next = ST_IDX;
              end
            end
            default: ;
          endcase
        end
      end
      ST_IDX: state_next = ST_SEL;
      ST_SEL: state_next = ST_MUL;
      ST_MUL: begin
        mul_en     = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        fin        = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // query datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      // t = p*n - 0.5 with 16 fraction bits
      t_val <= $signed(T_W'(in_prob) * T_W'(count)) - T_W'(1 << (FRAC_W - 1));
    end
    if (state == ST_IDX) begin
      idx0 <= i_clamp;
      idx1 <= i_clamp + IDX_W'(1);
      pos  <= POS_W'(pos_full);
    end
    if (state == ST_SEL) begin
      s0_q <= sel0;
      s1_q <= sel1;
    end
  end

  // result buffer: written on an immediate item or a finished query
  always_ff @(posedge clk) begin
    if (rst) begin
      done_valid <= 1'b0;
    end else if (in_xfer && !((in_func == FUNC_QUERY) && (count >= COUNT_W'(2)))) begin
      done_valid <= 1'b1;
    end else if (fin) begin
      done_valid <= 1'b1;
    end else if (done_valid && (!out_valid || m_axis_tready)) begin
      done_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      done_value  <= '0;
      done_count  <= COUNT_OUT_W'(count_next);
      done_status <= STATUS_OK;
      if ((in_func == FUNC_LOAD) && (count >= FULL_COUNT)) begin
        done_status <= STATUS_FULL;
      end else if ((in_func == FUNC_QUERY) && (count < COUNT_W'(2))) begin
        done_status <= STATUS_FEW;
      end
    end else if (fin) begin
      done_value  <= interp_result;
      done_status <= STATUS_OK;
      done_count  <= COUNT_OUT_W'(count);
    end
  end

  // output register, refilled from the buffer when free or taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      out_valid <= done_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (done_valid && (!out_valid || m_axis_tready)) begin
      out_value  <= done_value;
      out_status <= done_status;
      out_count  <= done_count;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_count, out_value};
  assign m_axis_tuser  = out_status;

endmodule
